[hw/rtl/cbs_pkg.sv]
// Shared types and constants for the chunk residence budget selector.
// No dependencies; imported by every module of the block.
package cbs_pkg;

   localparam int DIST_W = 32;
   localparam int CNT_W  = 7;
   localparam int MASK_W = 64;
   localparam int QUO_W  = 16;
   localparam int DEN_W  = 8;

   localparam logic [7:0]       DEFAULT_CHUNK = 8'd16;
   localparam logic [CNT_W-1:0] MIN_BUDGET    = 7'd1;

   localparam logic [2:0] CSR_MAP_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_MAP_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_CHUNK_SIZE = 3'd2;
   localparam logic [2:0] CSR_BUDGET     = 3'd3;

   typedef struct packed {
      logic [DIST_W-1:0] dsq;
      logic              live;
   } cbs_cell_type;

endpackage

[hw/rtl/cbs_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on cbs_pkg for the operand widths.
module cbs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [cbs_pkg::QUO_W-1:0] dividend,
   input  logic [cbs_pkg::DEN_W-1:0] divisor,
   output logic                      done,
   output logic [cbs_pkg::QUO_W-1:0] quotient
);
   import cbs_pkg::*;

   localparam int CW = $clog2(QUO_W);
   localparam logic [CW-1:0] LAST_STEP = CW'(QUO_W - 1);

   logic             run_ff,  run_in;
   logic [CW-1:0]    cnt_ff,  cnt_in;
   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [QUO_W-1:0] quo_ff,  quo_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial    = {rem_ff, quo_ff[QUO_W-1]};
      ge       = trial >= {1'b0, den_ff};
      quotient = {quo_ff[QUO_W-2:0], ge};
      done     = run_ff && (cnt_ff == LAST_STEP);
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
      end else if (run_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = quotient;
         cnt_in = cnt_ff + 1'b1;
         if (done) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

[hw/rtl/cbs_cell.sv]
// One cell of the chunk ring: holds the squared distance and residence of one chunk.
// Depends on cbs_pkg for the cell type.
module cbs_cell (
   input  logic                  clock,
   input  logic                  shift_en,
   input  cbs_pkg::cbs_cell_type load_data,
   output cbs_pkg::cbs_cell_type held_data
);
   import cbs_pkg::*;

   cbs_cell_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (shift_en) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held_data = data_ff;

endmodule

[hw/rtl/chunk_residence_budget_select.sv]
// Chunk residence selector with budget: top level with sequencer, distance pipe and cell ring.
// Depends on cbs_pkg, cbs_div and cbs_cell.
//
// One request is worked on at a time; busy is high from start until the result strobe.
// A request runs four divisions on the shared divider, one ring fill, then one full ring
// rotation per chunk dropped by the budget plus a final one.
// The result is shown for exactly one cycle with rsp_valid; the receiver cannot stall it.
module chunk_residence_budget_select #(
   parameter int MAX_CHUNKS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [15:0]         req_focus_x,
   input  logic signed [15:0]         req_focus_y,
   input  logic [7:0]                 req_radius,
   output logic                       rsp_valid,
   output logic [cbs_pkg::MASK_W-1:0] rsp_resident_mask,
   output logic [cbs_pkg::CNT_W-1:0]  rsp_resident_total,
   output logic                       rsp_grid_overflow,
   input  logic                       csr_wr_en,
   input  logic [2:0]                 csr_index,
   input  logic [11:0]                csr_wdata
);
   import cbs_pkg::*;

   localparam int IW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int NW = $clog2(MAX_CHUNKS + 1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_CHUNKS - 1);
   localparam logic [NW-1:0] ISSUE_END = NW'(MAX_CHUNKS);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DIV   = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_PRUNE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [11:0]      map_w_ff,   map_w_in;
   logic [11:0]      map_h_ff,   map_h_in;
   logic [7:0]       chunk_ff,   chunk_in;
   logic [CNT_W-1:0] budget_ff,  budget_in;

   logic [1:0]       div_sel_ff, div_sel_in;
   logic             div_run_ff, div_run_in;
   logic [NW-1:0]    iss_ff,     iss_in;
   logic             p0_vld_ff,  p0_vld_in;
   logic             p1_vld_ff,  p1_vld_in;
   logic [IW-1:0]    ld_cnt_ff,  ld_cnt_in;
   logic [IW-1:0]    pos_ff,     pos_in;
   logic             pend_vld_ff, pend_vld_in;
   logic             fnd_ff,     fnd_in;
   logic [CNT_W-1:0] count_ff,   count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] fx_ff,    fx_in;
   logic signed [15:0] fy_ff,    fy_in;
   logic [15:0]        r2_ff,    r2_in;
   logic [11:0]        cols_ff,  cols_in;
   logic [11:0]        rows_ff,  rows_in;
   logic signed [16:0] qfx_ff,   qfx_in;
   logic signed [16:0] qfy_ff,   qfy_in;
   logic [11:0]        cx_ff,    cx_in;
   logic [11:0]        cy_ff,    cy_in;
   logic               p0_in_ff, p0_in_in;
   logic [15:0]        adx_ff,   adx_in;
   logic [15:0]        ady_ff,   ady_in;
   logic               p1_in_ff, p1_in_in;
   logic [DIST_W-1:0]  sqx_ff,   sqx_in;
   logic [DIST_W-1:0]  sqy_ff,   sqy_in;
   logic               ovf_ff,   ovf_in;
   logic [DIST_W-1:0]  best_ff,  best_in;
   logic [IW-1:0]      bidx_ff,  bidx_in;
   logic [IW-1:0]      pidx_ff,  pidx_in;
   logic [MASK_W-1:0]  mask_ff,  mask_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic               flag_ff,  flag_in;

   logic [7:0]         side;
   logic [CNT_W-1:0]   lim;
   logic               div_go;
   logic               div_done;
   logic [QUO_W-1:0]   div_num;
   logic [QUO_W-1:0]   div_quo;
   logic [15:0]        abs_fx;
   logic [15:0]        abs_fy;
   logic signed [17:0] dx;
   logic signed [17:0] dy;
   logic               in_grid;
   logic [DIST_W-1:0]  dist_sum;
   cbs_cell_type       fresh;
   cbs_cell_type       head;
   cbs_cell_type       tail_in;
   logic               is_pend;
   logic               head_live;
   logic               take;
   logic               shift_en;
   logic [MASK_W-1:0]  ring_mask;
   cbs_cell_type       cq [MAX_CHUNKS];

   cbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_num),
      .divisor  (side),
      .done     (div_done),
      .quotient (div_quo)
   );

   for (genvar k = 0; k < MAX_CHUNKS; k++) begin : g_ring
      if (k == MAX_CHUNKS - 1) begin : g_tail
         cbs_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .load_data (tail_in),
            .held_data (cq[k])
         );
      end else begin : g_body
         cbs_cell u_cell (
            .clock     (clock),
            .shift_en  (shift_en),
            .load_data (cq[k+1]),
            .held_data (cq[k])
         );
      end
   end

   for (genvar b = 0; b < MASK_W; b++) begin : g_mask
      if (b < MAX_CHUNKS) begin : g_live
         assign ring_mask[b] = cq[b].live;
      end else begin : g_none
         assign ring_mask[b] = 1'b0;
      end
   end

   always_comb begin
      side     = (chunk_ff == 8'd0) ? DEFAULT_CHUNK : chunk_ff;
      lim      = (budget_ff == '0) ? MIN_BUDGET : budget_ff;
      abs_fx   = fx_ff[15] ? 16'(-fx_ff) : 16'(fx_ff);
      abs_fy   = fy_ff[15] ? 16'(-fy_ff) : 16'(fy_ff);
      div_go   = (state_ff == ST_DIV) && !div_run_ff;
      unique case (div_sel_ff)
         2'd0:    div_num = 16'(map_w_ff) + 16'(side) - 16'd1;
         2'd1:    div_num = 16'(map_h_ff) + 16'(side) - 16'd1;
         2'd2:    div_num = abs_fx;
         default: div_num = abs_fy;
      endcase

      in_grid  = (cy_ff < rows_ff) && (cols_ff != 12'd0);
      dx       = $signed({6'b0, cx_ff}) - $signed({qfx_ff[16], qfx_ff});
      dy       = $signed({6'b0, cy_ff}) - $signed({qfy_ff[16], qfy_ff});
      dist_sum = sqx_ff + sqy_ff;
      fresh.dsq  = dist_sum;
      fresh.live = p1_in_ff && (dist_sum <= DIST_W'(r2_ff));

      head      = cq[0];
      is_pend   = pend_vld_ff && (pos_ff == pidx_ff);
      head_live = head.live && !is_pend;
      take      = head_live && (!fnd_ff || (head.dsq > best_ff));
      tail_in   = (state_ff == ST_LOAD) ? fresh
                                        : cbs_cell_type'{dsq: head.dsq, live: head_live};
      shift_en  = ((state_ff == ST_LOAD) && p1_vld_ff) || (state_ff == ST_PRUNE);
   end

   always_comb begin
      state_in     = state_ff;
      map_w_in     = map_w_ff;
      map_h_in     = map_h_ff;
      chunk_in     = chunk_ff;
      budget_in    = budget_ff;
      div_sel_in   = div_sel_ff;
      div_run_in   = div_run_ff;
      iss_in       = iss_ff;
      p0_vld_in    = 1'b0;
      p1_vld_in    = 1'b0;
      ld_cnt_in    = ld_cnt_ff;
      pos_in       = pos_ff;
      pend_vld_in  = pend_vld_ff;
      fnd_in       = fnd_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      r2_in        = r2_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      qfx_in       = qfx_ff;
      qfy_in       = qfy_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      p0_in_in     = in_grid;
      adx_in       = dx[17] ? 16'(-dx) : 16'(dx);
      ady_in       = dy[17] ? 16'(-dy) : 16'(dy);
      p1_in_in     = p0_in_ff;
      sqx_in       = DIST_W'(adx_ff * adx_ff);
      sqy_in       = DIST_W'(ady_ff * ady_ff);
      ovf_in       = ovf_ff;
      best_in      = best_ff;
      bidx_in      = bidx_ff;
      pidx_in      = pidx_ff;
      mask_in      = mask_ff;
      total_in     = total_ff;
      flag_in      = flag_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_w_in  = csr_wdata;
            CSR_MAP_HEIGHT: map_h_in  = csr_wdata;
            CSR_CHUNK_SIZE: chunk_in  = csr_wdata[7:0];
            CSR_BUDGET:     budget_in = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               fx_in      = req_focus_x;
               fy_in      = req_focus_y;
               r2_in      = 16'(req_radius) * 16'(req_radius);
               div_sel_in = 2'd0;
               div_run_in = 1'b0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_go) begin
               div_run_in = 1'b1;
            end
            if (div_done) begin
               div_run_in = 1'b0;
               div_sel_in = div_sel_ff + 2'd1;
               unique case (div_sel_ff)
                  2'd0:    cols_in = div_quo[11:0];
                  2'd1:    rows_in = div_quo[11:0];
                  2'd2:    qfx_in  = fx_ff[15] ? -$signed({1'b0, div_quo})
                                               : $signed({1'b0, div_quo});
                  default: qfy_in  = fy_ff[15] ? -$signed({1'b0, div_quo})
                                               : $signed({1'b0, div_quo});
               endcase
               if (div_sel_ff == 2'd3) begin
                  iss_in    = '0;
                  cx_in     = '0;
                  cy_in     = '0;
                  ld_cnt_in = '0;
                  count_in  = '0;
                  state_in  = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            p1_vld_in = p0_vld_ff;
            if (iss_ff != ISSUE_END) begin
               p0_vld_in = 1'b1;
               iss_in    = iss_ff + 1'b1;
               if (cx_ff + 12'd1 == cols_ff) begin
                  cx_in = '0;
                  cy_in = cy_ff + 12'd1;
               end else begin
                  cx_in = cx_ff + 12'd1;
               end
            end else begin
               ovf_in = in_grid;
            end
            if (p1_vld_ff) begin
               ld_cnt_in = ld_cnt_ff + 1'b1;
               count_in  = count_ff + CNT_W'(fresh.live);
               if (ld_cnt_ff == LAST_IDX) begin
                  pos_in      = '0;
                  fnd_in      = 1'b0;
                  pend_vld_in = 1'b0;
                  state_in    = ST_PRUNE;
               end
            end
         end
         ST_PRUNE: begin
            if (take) begin
               best_in = head.dsq;
               bidx_in = pos_ff;
               fnd_in  = 1'b1;
            end
            pos_in = pos_ff + 1'b1;
            if (pos_ff == LAST_IDX) begin
               pos_in = '0;
               fnd_in = 1'b0;
               if (count_ff > lim) begin
                  pidx_in     = take ? pos_ff : bidx_ff;
                  pend_vld_in = 1'b1;
                  count_in    = count_ff - 1'b1;
               end else begin
                  pend_vld_in = 1'b0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            mask_in      = ring_mask;
            total_in     = count_ff;
            flag_in      = ovf_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_w_ff     <= '0;
         map_h_ff     <= '0;
         chunk_ff     <= DEFAULT_CHUNK;
         budget_ff    <= MIN_BUDGET;
         div_sel_ff   <= '0;
         div_run_ff   <= 1'b0;
         iss_ff       <= '0;
         p0_vld_ff    <= 1'b0;
         p1_vld_ff    <= 1'b0;
         ld_cnt_ff    <= '0;
         pos_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         fnd_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         map_w_ff     <= map_w_in;
         map_h_ff     <= map_h_in;
         chunk_ff     <= chunk_in;
         budget_ff    <= budget_in;
         div_sel_ff   <= div_sel_in;
         div_run_ff   <= div_run_in;
         iss_ff       <= iss_in;
         p0_vld_ff    <= p0_vld_in;
         p1_vld_ff    <= p1_vld_in;
         ld_cnt_ff    <= ld_cnt_in;
         pos_ff       <= pos_in;
         pend_vld_ff  <= pend_vld_in;
         fnd_ff       <= fnd_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fx_ff    <= fx_in;
      fy_ff    <= fy_in;
      r2_ff    <= r2_in;
      cols_ff  <= cols_in;
      rows_ff  <= rows_in;
      qfx_ff   <= qfx_in;
      qfy_ff   <= qfy_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      p0_in_ff <= p0_in_in;
      adx_ff   <= adx_in;
      ady_ff   <= ady_in;
      p1_in_ff <= p1_in_in;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      ovf_ff   <= ovf_in;
      best_ff  <= best_in;
      bidx_ff  <= bidx_in;
      pidx_ff  <= pidx_in;
      mask_ff  <= mask_in;
      total_ff <= total_in;
      flag_ff  <= flag_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_resident_mask  = mask_ff;
   assign rsp_resident_total = total_ff;
   assign rsp_grid_overflow  = flag_ff;

endmodule
